@@ hw/rtl/ldcg_pkg.sv @@
package ldcg_pkg;

    localparam int DIV_W = 24;
    localparam int DVS_W = 9;
    localparam int CNT_W = 5;

    localparam logic [1:0] CMD_TX     = 2'd0;
    localparam logic [1:0] CMD_REFILL = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] CFG_LOW = 2'd0;
    localparam logic [1:0] CFG_ONE = 2'd1;
    localparam logic [1:0] CFG_TEN = 2'd2;

    localparam logic [1:0] BAND_LOW = 2'd0;
    localparam logic [1:0] BAND_ONE = 2'd1;
    localparam logic [1:0] BAND_TEN = 2'd2;

    localparam logic [29:0] ONE_LO_HZ = 30'd868000000;
    localparam logic [29:0] ONE_HI_HZ = 30'd868600000;
    localparam logic [29:0] TEN_LO_HZ = 30'd869400000;
    localparam logic [29:0] TEN_HI_HZ = 30'd869650000;

    localparam logic [19:0] RST_LOW = 20'd3600;
    localparam logic [19:0] RST_ONE = 20'd36000;
    localparam logic [19:0] RST_TEN = 20'd360000;

    // 12.25 + 8 symbols, in quarter symbols
    localparam logic [11:0] BASE_QSYM = 12'd81;
    // x / 500 as ((x >> 2) * ceil(2^28 / 125)) >> 28, exact for x below 2^24
    localparam int          RCP_SHIFT = 28;
    localparam logic [21:0] RCP_125   = 22'd2147484;
    localparam logic [CNT_W-1:0] STEPS_BLK  = 5'd12;
    localparam logic [15:0] MAX_AIR_MS = 16'd19800;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hw/rtl/ldcg_div.sv @@
module ldcg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ldcg_pkg::t_div_req i_req,
    output ldcg_pkg::t_div_rsp o_rsp
);
    import ldcg_pkg::*;

    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ hw/rtl/lora_duty_cycle_gate.sv @@
// Channel   Handshake                   Payload
// in        i_in_valid / o_in_ready     i_command, i_carrier_hz, i_spreading_factor,
//                                       i_bandwidth_code, i_coding_rate, i_payload_bytes
// out       o_out_valid / i_out_ready   o_granted, o_airtime_ms, o_remaining_ms
// cfg       i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
// Transmit request: the shift-subtract divider runs 12 steps for the payload block
// count, S_MUL shifts the symbol count by spreading factor less bandwidth and S_RCP
// divides by 500 with a reciprocal multiply; the divider is skipped when the payload
// needs no blocks. Refill and query go straight to the final step, S_FIN.
// One item at a time; the next item is taken while a result waits, and its own
// result then holds in the last step until the output register frees.
// Reset is synchronous and loads the register reset values into the budgets.
module lora_duty_cycle_gate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [29:0] i_carrier_hz,
    input  logic [3:0]  i_spreading_factor,
    input  logic [1:0]  i_bandwidth_code,
    input  logic [1:0]  i_coding_rate,
    input  logic [7:0]  i_payload_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_granted,
    output logic [15:0] o_airtime_ms,
    output logic [19:0] o_remaining_ms
);
    import ldcg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_MUL,
        S_RCP,
        S_FIN
    } t_state;

    t_state      r_state;
    logic [19:0] r_cfg_low, r_cfg_one, r_cfg_ten;
    logic [19:0] r_left_low, r_left_one, r_left_ten;
    logic [1:0]  r_cmd, r_band, r_bw, r_cr;
    logic [3:0]  r_sf;
    logic [6:0]  r_blocks;
    logic [DIV_W-1:0] r_xval;
    logic [15:0] r_air;
    logic        r_out_valid, r_granted;
    logic [15:0] r_airtime;
    logic [19:0] r_remaining;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic        accept, load, fits;
    logic [3:0]  sf_c;
    logic        de;
    logic [1:0]  bw_e, band_in;
    logic [5:0]  den;
    logic [11:0] num_a, num_b, num_up;
    logic        num_pos;
    logic [3:0]  cr5;
    logic [10:0] prod;
    logic [11:0] qsym;
    logic [3:0]  shamt;
    logic [DIV_W-1:0] xval;
    logic [43:0] rcp_prod;
    logic [19:0] cur, cfg_sel, n_left;
    logic        n_granted;
    logic [15:0] n_airtime;
    logic [19:0] n_remaining;

    ldcg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        accept = i_in_valid && (r_state == S_IDLE);
        load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

        if (i_spreading_factor < 4'd7) begin
            sf_c = 4'd7;
        end else if (i_spreading_factor > 4'd12) begin
            sf_c = 4'd12;
        end else begin
            sf_c = i_spreading_factor;
        end
        de      = sf_c >= 4'd11;
        den     = {(sf_c - {2'b00, de, 1'b0}), 2'b00};
        num_a   = {1'b0, i_payload_bytes, 3'b000} + 12'd24;
        num_b   = {6'd0, sf_c, 2'b00};
        num_pos = num_a > num_b;
        num_up  = num_a - num_b + {6'd0, den} - 12'd1;
        bw_e    = (i_bandwidth_code == 2'd3) ? 2'd2 : i_bandwidth_code;

        if (i_carrier_hz >= ONE_LO_HZ && i_carrier_hz <= ONE_HI_HZ) begin
            band_in = BAND_ONE;
        end else if (i_carrier_hz >= TEN_LO_HZ && i_carrier_hz <= TEN_HI_HZ) begin
            band_in = BAND_TEN;
        end else begin
            band_in = BAND_LOW;
        end

        cr5   = {2'b00, r_cr} + 4'd5;
        prod  = 11'(r_blocks) * 11'(cr5);
        qsym  = BASE_QSYM + 12'({prod, 2'b00});
        shamt = r_sf - {2'b00, r_bw};
        xval  = DIV_W'(qsym) << shamt;

        rcp_prod = 44'(r_xval[DIV_W-1:2]) * 44'(RCP_125);

        div_req.start    = accept && i_command == CMD_TX && num_pos;
        div_req.dividend = {num_up, 12'd0};
        div_req.divisor  = {3'b000, den};
        div_req.steps    = STEPS_BLK;

        case (r_band)
            BAND_ONE: begin
                cur     = r_left_one;
                cfg_sel = r_cfg_one;
            end
            BAND_TEN: begin
                cur     = r_left_ten;
                cfg_sel = r_cfg_ten;
            end
            default: begin
                cur     = r_left_low;
                cfg_sel = r_cfg_low;
            end
        endcase
        fits   = {4'd0, r_air} <= cur;
        n_left = cur - {4'd0, r_air};

        n_granted   = 1'b0;
        n_airtime   = '0;
        n_remaining = cur;
        case (r_cmd)
            CMD_TX: begin
                n_airtime = r_air;
                if (fits) begin
                    n_granted   = 1'b1;
                    n_remaining = n_left;
                end
            end
            CMD_REFILL: n_remaining = cfg_sel;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_low   <= RST_LOW;
            r_cfg_one   <= RST_ONE;
            r_cfg_ten   <= RST_TEN;
            r_left_low  <= RST_LOW;
            r_left_one  <= RST_ONE;
            r_left_ten  <= RST_TEN;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LOW: r_cfg_low <= i_cfg_data;
                    CFG_ONE: r_cfg_one <= i_cfg_data;
                    CFG_TEN: r_cfg_ten <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd  <= i_command;
                        r_band <= band_in;
                        r_sf   <= sf_c;
                        r_bw   <= bw_e;
                        r_cr   <= i_coding_rate;
                        r_air  <= '0;
                        if (i_command == CMD_TX) begin
                            if (num_pos) begin
                                r_state <= S_DIV1;
                            end else begin
                                r_blocks <= '0;
                                r_state  <= S_MUL;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        r_blocks <= div_rsp.quotient[6:0];
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_xval  <= xval;
                    r_state <= S_RCP;
                end
                S_RCP: begin
                    r_air   <= rcp_prod[RCP_SHIFT +: 16];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (load) begin
                        r_granted   <= n_granted;
                        r_airtime   <= n_airtime;
                        r_remaining <= n_remaining;
                        case (r_cmd)
                            CMD_TX: begin
                                if (fits) begin
                                    case (r_band)
                                        BAND_ONE: r_left_one <= n_left;
                                        BAND_TEN: r_left_ten <= n_left;
                                        default:  r_left_low <= n_left;
                                    endcase
                                end
                            end
                            CMD_REFILL: begin
                                r_left_low  <= r_cfg_low;
                                r_left_one  <= r_cfg_one;
                                r_left_ten  <= r_cfg_ten;
                            end
                            default: ;
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_granted;
    assign o_airtime_ms   = r_airtime;
    assign o_remaining_ms = r_remaining;

    a_deduct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_cmd == CMD_TX && fits) |=> (cur == $past(n_left)))
        else $error("granted airtime not deducted from band budget");

    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV1))
        else $error("divider finished outside a divide step");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_rsp.busy)
        else $error("divider busy while taking a new item");

    a_air_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_airtime_ms <= MAX_AIR_MS))
        else $error("airtime beyond longest packet");

endmodule
